// ----- hdl/swmf_pkg.sv -----
`timescale 1ns / 1ps

package swmf_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_WINDOW_DEF = 7;
    localparam int PIX_W          = 8;
    localparam int ROW_W          = 12;
    localparam int COL_W          = 11;
    localparam int WSIZE_W        = 3;
    localparam int IWIDTH_W       = 12;
    localparam int IHEIGHT_W      = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int MAX_HEIGHT     = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

// ----- hdl/swmf_cell.sv -----
`timescale 1ns / 1ps

// One compare-exchange cell of the odd-even transposition sorting chain.
// On load it takes a window pixel or a pad value; on each shift cycle it
// exchanges with its neighbor in the phase that the parity selects.
module swmf_cell
(
    input  logic                           clk,
    input  swmf_pkg::cell_ctrl_t           ctrl,
    input  logic [swmf_pkg::PIX_W-1:0]     load_val,
    input  logic [swmf_pkg::PIX_W-1:0]     left_val,
    input  logic                           has_left,
    input  logic [swmf_pkg::PIX_W-1:0]     right_val,
    input  logic                           has_right,
    input  logic                           pair_right,
    output logic [swmf_pkg::PIX_W-1:0]     val
);

    logic [swmf_pkg::PIX_W-1:0] val_reg;
    logic [swmf_pkg::PIX_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.load)
        begin
            val_next = load_val;
        end
        else if (ctrl.shift)
        begin
            if (pair_right && has_right)
            begin
                val_next = (val_reg < right_val) ? val_reg : right_val;
            end
            else if (!pair_right && has_left)
            begin
                val_next = (left_val > val_reg) ? left_val : val_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ----- hdl/swmf_line_buf.sv -----
`timescale 1ns / 1ps

// One line of pixel storage with a registered read.
module swmf_line_buf #(
    parameter int MAX_WIDTH = swmf_pkg::MAX_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(MAX_WIDTH)-1:0] addr,
    input  logic [swmf_pkg::PIX_W-1:0]   wdata,
    output logic [swmf_pkg::PIX_W-1:0]   rdata
);

    logic [swmf_pkg::PIX_W-1:0] mem [MAX_WIDTH];
    logic [swmf_pkg::PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/sliding_window_median_filter.sv -----
`timescale 1ns / 1ps

// Streaming two-dimensional median filter for 8-bit pixels in raster order.
// Each accepted pixel completes the window whose bottom-right corner it is;
// for interior positions one result carries the window median and the
// center's row and column, border positions give none. Between one
// accepted pixel and the next, an interior item passes through the accept
// state, a line buffer read, a window update, a load of the sorting chain,
// the passes of the odd-even transposition chain and the presentation of
// the result; a border item returns to idle after the chain load. No new
// pixel is taken before the last is done. A stalled result holds off the
// input for as long as it waits. No clearing pass is needed after reset.
// Configuration is written only while idle.
module sliding_window_median_filter #(
    parameter int MAX_WIDTH  = swmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = swmf_pkg::MAX_WINDOW_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [swmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swmf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [swmf_pkg::PIX_W-1:0]         pixel,
    input  logic                               frame_start,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [swmf_pkg::PIX_W-1:0]         median_value,
    output logic [swmf_pkg::ROW_W-1:0]         out_row,
    output logic [swmf_pkg::COL_W-1:0]         out_col
);

    localparam int LINES  = MAX_WINDOW - 1;
    localparam int CELLS  = MAX_WINDOW * MAX_WINDOW;
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int CW     = AW + 1;
    localparam int SCW    = $clog2(CELLS + 1);
    localparam int LW     = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int NW     = $clog2(MAX_WINDOW + 1);
    localparam int MAXODD = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;
    localparam int PW     = swmf_pkg::PIX_W;
    localparam int RCW    = swmf_pkg::ROW_W + 1;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_WIN, S_LOAD, S_SORT, S_OUT} state_t;

    state_t                           state_reg;
    logic [swmf_pkg::WSIZE_W-1:0]     wsize_reg;
    logic [swmf_pkg::IWIDTH_W-1:0]    iwidth_reg;
    logic [swmf_pkg::IHEIGHT_W-1:0]   iheight_reg;
    logic [RCW-1:0]                   row_reg;
    logic [LW-1:0]                    rowm_reg;
    logic [CW-1:0]                    col_reg;
    logic [RCW-1:0]                   r_reg;
    logic [AW-1:0]                    c_reg;
    logic [CW-1:0]                    cfull_reg;
    logic [LW-1:0]                    rm_reg;
    logic [PW-1:0]                    px_reg;
    logic [SCW-1:0]                   cnt_reg;
    logic                             hit_reg;
    logic [PW-1:0]                    win_reg [MAX_WINDOW][MAX_WINDOW];
    logic [PW-1:0]                    med_reg;
    logic [swmf_pkg::ROW_W-1:0]       orow_reg;
    logic [swmf_pkg::COL_W-1:0]       ocol_reg;
    logic                             ovalid_reg;

    logic [NW-1:0]   n_eff;
    logic [NW-1:0]   adj;
    logic [CW-1:0]   w_eff;
    logic [RCW-1:0]  h_eff;
    logic [RCW-1:0]  r_pos;
    logic [CW-1:0]   c_pos;
    logic [CW-1:0]   c_wrap;
    logic [RCW-1:0]  r_wrap;
    logic [LW-1:0]   rm_next;
    logic [PW-1:0]   lb_rdata [LINES];
    logic [PW-1:0]   cell_val [CELLS];
    swmf_pkg::cell_ctrl_t cctrl;

    always_comb
    begin
        n_eff = NW'(wsize_reg);
        if (32'(wsize_reg) > MAXODD)
        begin
            n_eff = NW'(MAXODD);
        end
        else if (wsize_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (!wsize_reg[0])
        begin
            n_eff = NW'(wsize_reg) - NW'(1);
        end
        adj = n_eff >> 1;

        w_eff = CW'(iwidth_reg);
        if (iwidth_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(iwidth_reg) > MAX_WIDTH)
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        h_eff = RCW'(iheight_reg);
        if (iheight_reg == '0)
        begin
            h_eff = RCW'(1);
        end
        else if (32'(iheight_reg) > swmf_pkg::MAX_HEIGHT)
        begin
            h_eff = RCW'(swmf_pkg::MAX_HEIGHT);
        end

        r_wrap  = frame_start ? '0 : row_reg;
        rm_next = frame_start ? '0 : rowm_reg;
        c_wrap  = frame_start ? '0 : col_reg;
        if (c_wrap >= w_eff)
        begin
            c_wrap  = '0;
            r_wrap  = r_wrap + RCW'(1);
            rm_next = (rm_next == LW'(LINES - 1)) ? '0 : rm_next + LW'(1);
        end
        if (r_wrap >= h_eff)
        begin
            r_wrap  = '0;
            rm_next = '0;
        end
        r_pos = r_wrap;
        c_pos = c_wrap;
    end

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE);

    genvar gl;
    generate
        for (gl = 0; gl < LINES; gl++)
        begin : g_line
            swmf_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line (
                .clk   (clk),
                .we    ((state_reg == S_WIN) && (rm_reg == LW'(gl))),
                .addr  (c_reg),
                .wdata (px_reg),
                .rdata (lb_rdata[gl])
            );
        end
    endgenerate

    // The chain holds CELLS values; cells outside the active window load the
    // extreme values alternately so the median index of the chain stays fixed.
    assign cctrl.load  = (state_reg == S_LOAD);
    assign cctrl.shift = (state_reg == S_SORT);

    genvar gc;
    generate
        for (gc = 0; gc < CELLS; gc++)
        begin : g_cell
            localparam int CI = gc / MAX_WINDOW;
            localparam int RJ = gc % MAX_WINDOW;
            logic [PW-1:0] ld;
            always_comb
            begin
                if ((32'(CI) >= MAX_WINDOW - 32'(n_eff)) && (32'(RJ) >= MAX_WINDOW - 32'(n_eff)))
                begin
                    ld = win_reg[CI][RJ];
                end
                else
                begin
                    ld = (gc % 2 == 0) ? '0 : '1;
                end
            end
            swmf_cell u_cell (
                .clk        (clk),
                .ctrl       (cctrl),
                .load_val   (ld),
                .left_val   (cell_val[(gc > 0) ? gc - 1 : 0]),
                .has_left   (gc > 0),
                .right_val  (cell_val[(gc < CELLS - 1) ? gc + 1 : gc]),
                .has_right  (gc < CELLS - 1),
                .pair_right ((cnt_reg[0] ^ (gc % 2 == 1))),
                .val        (cell_val[gc])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wsize_reg   <= swmf_pkg::WSIZE_W'(3);
            iwidth_reg  <= swmf_pkg::IWIDTH_W'(640);
            iheight_reg <= swmf_pkg::IHEIGHT_W'(480);
            row_reg     <= '0;
            rowm_reg    <= '0;
            col_reg     <= '0;
            ovalid_reg  <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    swmf_pkg::REG_WINDOW_SIZE:
                        wsize_reg <= cfg_data[swmf_pkg::WSIZE_W-1:0];
                    swmf_pkg::REG_IMAGE_WIDTH:
                        iwidth_reg <= cfg_data[swmf_pkg::IWIDTH_W-1:0];
                    swmf_pkg::REG_IMAGE_HEIGHT:
                        iheight_reg <= cfg_data[swmf_pkg::IHEIGHT_W-1:0];
                    default:
                        ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        r_reg     <= r_pos;
                        c_reg     <= c_pos[AW-1:0];
                        cfull_reg <= c_pos;
                        rm_reg    <= rm_next;
                        px_reg    <= pixel;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_WIN;
                end
                S_WIN:
                begin
                    for (int i = 0; i < MAX_WINDOW - 1; i++)
                    begin
                        for (int j = 0; j < MAX_WINDOW; j++)
                        begin
                            win_reg[i][j] <= win_reg[i + 1][j];
                        end
                    end
                    for (int k = 1; k <= LINES; k++)
                    begin
                        win_reg[MAX_WINDOW - 1][MAX_WINDOW - 1 - k] <=
                            lb_rdata[(rm_reg >= LW'(k)) ? (rm_reg - LW'(k))
                                                        : (rm_reg + LW'(LINES - k))];
                    end
                    win_reg[MAX_WINDOW - 1][MAX_WINDOW - 1] <= px_reg;
                    hit_reg <= (r_reg >= RCW'({adj, 1'b0})) && (cfull_reg >= CW'({adj, 1'b0}));
                    if (cfull_reg + CW'(1) >= w_eff)
                    begin
                        col_reg <= '0;
                        row_reg <= (r_reg + RCW'(1) >= h_eff) ? '0 : r_reg + RCW'(1);
                        if (r_reg + RCW'(1) >= h_eff)
                        begin
                            rowm_reg <= '0;
                        end
                        else
                        begin
                            rowm_reg <= (rm_reg == LW'(LINES - 1)) ? '0 : rm_reg + LW'(1);
                        end
                    end
                    else
                    begin
                        col_reg  <= cfull_reg + CW'(1);
                        row_reg  <= r_reg;
                        rowm_reg <= rm_reg;
                    end
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= hit_reg ? S_SORT : S_IDLE;
                end
                S_SORT:
                begin
                    cnt_reg <= cnt_reg + SCW'(1);
                    if (cnt_reg == SCW'(CELLS))
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        ovalid_reg <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SORT && cnt_reg == SCW'(CELLS))
        begin
            med_reg  <= cell_val[CELLS / 2];
            orow_reg <= swmf_pkg::ROW_W'(r_reg - RCW'(adj));
            ocol_reg <= swmf_pkg::COL_W'(cfull_reg - CW'(adj));
        end
    end

    assign out_valid    = ovalid_reg;
    assign median_value = med_reg;
    assign out_row      = orow_reg;
    assign out_col      = ocol_reg;

    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median_value))
        else $error("Result changed while stalled.");
    ap_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("Input ready while a result is pending.");
    ap_sort_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_SORT)
        else $error("Result raised outside of the sort pass.");

endmodule

// ----- verif/sliding_window_median_filter_tb.sv -----
`timescale 1ns / 1ps

module sliding_window_median_filter_tb;

    localparam int LINES       = swmf_pkg::MAX_WINDOW_DEF - 1;
    localparam int MWIN        = swmf_pkg::MAX_WINDOW_DEF;
    localparam int MWID        = swmf_pkg::MAX_WIDTH_DEF;
    localparam int DRAIN_WAIT  = 80;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        bit [swmf_pkg::PIX_W-1:0] med;
        bit [swmf_pkg::ROW_W-1:0] row;
        bit [swmf_pkg::COL_W-1:0] col;
    } median_result_t;

    class median_scoreboard;
        int unsigned win_size;
        int unsigned img_w;
        int unsigned img_h;
        bit [swmf_pkg::PIX_W-1:0] line_mem [0:LINES*MWID-1];
        bit [swmf_pkg::PIX_W-1:0] win [0:MWIN-1][0:MWIN-1];
        int unsigned row_pos;
        int unsigned col_pos;
        median_result_t pending [$];
        int errors;

        function new();
            win_size = 3;
            img_w = 640;
            img_h = 480;
            row_pos = 0;
            col_pos = 0;
            errors = 0;
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (win[i, j]) win[i][j] = '0;
        endfunction

        function void write_reg(logic [swmf_pkg::CFG_IDX_W-1:0] idx,
                                logic [swmf_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                swmf_pkg::REG_WINDOW_SIZE:  win_size = 32'(data[swmf_pkg::WSIZE_W-1:0]);
                swmf_pkg::REG_IMAGE_WIDTH:  img_w = 32'(data[swmf_pkg::IWIDTH_W-1:0]);
                swmf_pkg::REG_IMAGE_HEIGHT: img_h = 32'(data[swmf_pkg::IHEIGHT_W-1:0]);
                default: ;
            endcase
        endfunction

        function void note_pixel(bit [swmf_pkg::PIX_W-1:0] px, bit fs);
            int unsigned w, h, n, adj, r, c, rm, slot, cnt, j;
            bit [swmf_pkg::PIX_W-1:0] vals [0:MWIN*MWIN-1];
            bit [swmf_pkg::PIX_W-1:0] key;
            median_result_t res;
            w = (img_w == 0) ? 1 : (img_w > MWID ? MWID : img_w);
            h = (img_h == 0) ? 1 : (img_h > swmf_pkg::MAX_HEIGHT ? swmf_pkg::MAX_HEIGHT : img_h);
            n = (win_size > MWIN) ? MWIN : win_size;
            if (n == 0) n = 1;
            if (n % 2 == 0) n = n - 1;
            adj = n / 2;
            if (fs) begin
                row_pos = 0;
                col_pos = 0;
            end
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) row_pos = 0;
            r = row_pos;
            c = col_pos;
            for (int i = 0; i < MWIN - 1; i++)
                for (int k = 0; k < MWIN; k++)
                    win[i][k] = win[i+1][k];
            rm = r % LINES;
            for (int k = 1; k <= LINES; k++) begin
                slot = (rm + LINES - k) % LINES;
                win[MWIN-1][MWIN-1-k] = line_mem[slot*MWID + c];
            end
            win[MWIN-1][MWIN-1] = px;
            line_mem[rm*MWID + c] = px;
            if (r >= 2*adj && c >= 2*adj) begin
                cnt = 0;
                for (int i = MWIN - n; i < MWIN; i++)
                    for (int k = MWIN - n; k < MWIN; k++)
                        vals[cnt++] = win[i][k];
                for (int i = 1; i < cnt; i++) begin
                    key = vals[i];
                    j = i;
                    while (j > 0 && vals[j-1] > key) begin
                        vals[j] = vals[j-1];
                        j--;
                    end
                    vals[j] = key;
                end
                res.med = vals[cnt/2];
                res.row = swmf_pkg::ROW_W'(r - adj);
                res.col = swmf_pkg::COL_W'(c - adj);
                pending.push_back(res);
            end
            col_pos = c + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= h) row_pos = 0;
            end
        endfunction

        function void check_result(bit [swmf_pkg::PIX_W-1:0] med,
                                   bit [swmf_pkg::ROW_W-1:0] row,
                                   bit [swmf_pkg::COL_W-1:0] col);
            median_result_t exp_res;
            if (pending.size() == 0) begin
                $error("unexpected result transaction: median_value %0d out_row %0d out_col %0d",
                       med, row, col);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (med !== exp_res.med) begin
                $error("median_value: expected %0d, actual %0d", exp_res.med, med);
                errors++;
            end
            if (row !== exp_res.row) begin
                $error("out_row: expected %0d, actual %0d", exp_res.row, row);
                errors++;
            end
            if (col !== exp_res.col) begin
                $error("out_col: expected %0d, actual %0d", exp_res.col, col);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [swmf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [swmf_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [swmf_pkg::PIX_W-1:0]      pixel;
    logic                            frame_start;
    logic                            out_valid;
    logic                            out_ready;
    logic [swmf_pkg::PIX_W-1:0]      median_value;
    logic [swmf_pkg::ROW_W-1:0]      out_row;
    logic [swmf_pkg::COL_W-1:0]      out_col;

    median_scoreboard sb;
    int  cycle_count;
    int  burst_left;
    int  pixels_sent;
    bit  hold_req;
    bit  hold_done;

    sliding_window_median_filter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel        (pixel),
        .frame_start  (frame_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .median_value (median_value),
        .out_row      (out_row),
        .out_col      (out_col)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sliding_window_median_filter_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(median_value, out_row, out_col);
    end

    initial
    begin
        int mode;
        int span;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            for (int i = 0; i < span; i++)
            begin
                @(posedge clk);
                if (hold_req) begin
                    out_ready <= 1'b0;
                    repeat (700) @(posedge clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    2: out_ready <= ($urandom_range(0, 7) == 0);
                    default: out_ready <= ((i % 5) != 0);
                endcase
            end
        end
    end

    task automatic write_config(int unsigned ws, int unsigned w, int unsigned h);
        logic [swmf_pkg::CFG_IDX_W-1:0]  idx [3];
        logic [swmf_pkg::CFG_DATA_W-1:0] val [3];
        idx[0] = swmf_pkg::REG_WINDOW_SIZE;
        idx[1] = swmf_pkg::REG_IMAGE_WIDTH;
        idx[2] = swmf_pkg::REG_IMAGE_HEIGHT;
        val[0] = swmf_pkg::CFG_DATA_W'(ws);
        val[1] = swmf_pkg::CFG_DATA_W'(w);
        val[2] = swmf_pkg::CFG_DATA_W'(h);
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(bit [swmf_pkg::PIX_W-1:0] px, bit fs);
        int gap;
        in_valid    <= 1'b1;
        pixel       <= px;
        frame_start <= fs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_pixel(px, fs);
        pixels_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            gap = $urandom_range(1, 120);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 8);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic bit [swmf_pkg::PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return swmf_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_random_frame(int unsigned ws, int unsigned w, int unsigned h);
        int unsigned ew, eh, count;
        write_config(ws, w, h);
        ew = (w == 0) ? 1 : w;
        eh = (h == 0) ? 1 : h;
        count = ew * eh * $urandom_range(1, 2) + $urandom_range(0, 6);
        if (count > 220) count = 220;
        for (int i = 0; i < count; i++)
        begin
            if (!hold_done && pixels_sent > 200 && i == 5) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            send_pixel(random_pixel(), (i == 0) || ($urandom_range(0, 80) == 0));
        end
        wait_drained();
    endtask

    initial
    begin
        int unsigned ws, w, h;
        sb = new();
        cycle_count = 0;
        burst_left = 0;
        pixels_sent = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel = '0;
        frame_start = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_config(3, 4, 4);
        for (int i = 0; i < 16; i++)
            send_pixel((i % 3 == 0) ? 8'hFF
                                    : ((i % 3 == 1) ? 8'h00 : swmf_pkg::PIX_W'(i * 15)),
                       i == 0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h80, 1'b1);
        for (int i = 0; i < 5; i++)
            send_pixel(swmf_pkg::PIX_W'(255 - i), 1'b0);
        wait_drained();

        write_config(1, 2048, 1);
        for (int i = 0; i < 20; i++)
            send_pixel(random_pixel(), i == 0);
        wait_drained();

        run_random_frame(7, 4095, 4096);
        run_random_frame(7, 7, 7);
        run_random_frame(0, 0, 0);
        run_random_frame(4, 6, 5);
        run_random_frame(6, 9, 8);
        run_random_frame(2, 3, 3);

        while (pixels_sent < 850)
        begin
            ws = $urandom_range(0, 7);
            w  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            h  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            run_random_frame(ws, w, h);
        end

        write_config(3, 640, 480);
        wait_drained();

        if (sb.errors == 0) begin
            $display("sliding_window_median_filter_tb passed");
        end
        else begin
            $display("sliding_window_median_filter_tb failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/swmf_pkg.sv
hdl/swmf_cell.sv
hdl/swmf_line_buf.sv
hdl/sliding_window_median_filter.sv
verif/sliding_window_median_filter_tb.sv
